// ===== rtl/cds_pkg.sv =====
package cds_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_VELOCITY_SETPOINT = 2'd0,
        REG_PROFILE_ACCEL     = 2'd1,
        REG_PROFILE_DECEL     = 2'd2,
        REG_DRIVE_ENABLE      = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_UNKNOWN   = 4'd0,
        ST_NOT_READY = 4'd1,
        ST_DISABLED  = 4'd2,
        ST_READY     = 4'd3,
        ST_SWITCHED  = 4'd4,
        ST_ENABLED   = 4'd5,
        ST_QSTOP     = 4'd6,
        ST_FREACT    = 4'd7,
        ST_FAULT     = 4'd8
    } drive_state_t;

    // Statusword masks and patterns of the standard state table.
    localparam logic [6:0] MASK_A     = 7'h4F;
    localparam logic [6:0] MASK_B     = 7'h6F;
    localparam logic [6:0] PAT_FREACT = 7'h0F;
    localparam logic [6:0] PAT_FAULT  = 7'h08;
    localparam logic [6:0] PAT_DISAB  = 7'h40;
    localparam logic [6:0] PAT_NREADY = 7'h00;
    localparam logic [6:0] PAT_QSTOP  = 7'h07;
    localparam logic [6:0] PAT_ENAB   = 7'h27;
    localparam logic [6:0] PAT_SWON   = 7'h23;
    localparam logic [6:0] PAT_READY  = 7'h21;

    localparam logic [15:0] IDX_CONTROL  = 16'h6040;
    localparam logic [15:0] IDX_MODE     = 16'h6060;
    localparam logic [15:0] IDX_ACCEL    = 16'h6083;
    localparam logic [15:0] IDX_DECEL    = 16'h6084;
    localparam logic [15:0] IDX_VELOCITY = 16'h60FF;

    localparam logic [31:0] CW_SHUTDOWN  = 32'h06;
    localparam logic [31:0] CW_SWITCH_ON = 32'h07;
    localparam logic [31:0] CW_ENABLE_OP = 32'h0F;
    localparam logic [31:0] CW_DIS_VOLT  = 32'h00;
    localparam logic [31:0] CW_FAULT_RST = 32'h80;
    localparam logic [31:0] MODE_PV      = 32'd3;

    typedef struct packed {
        logic signed [31:0] velocity_setpoint;
        logic [30:0]        profile_accel;
        logic [30:0]        profile_decel;
        logic               drive_enable;
    } cfg_t;

    // One classified item as it waits between front and back.
    typedef struct packed {
        drive_state_t state;
        logic         changed;
    } plan_t;

endpackage

// ===== rtl/cia402_drive_enable_sequencer.sv =====
// Each item gives one to four results, one per cycle from the back-end step counter
// while the output register is free or being popped. An item with one result can be
// accepted every cycle while the queue is not full; one with more results holds the
// back end until its last result loads; the two-entry queue absorbs the difference.
// Reset clears the configuration registers to zero, the last state to unknown,
// and empties the queue and the output register.
module cia402_drive_enable_sequencer #(
    parameter int QUEUE_DEPTH = cds_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cds_pkg::ADDR_W-1:0]    paddr,
    input  logic [cds_pkg::DATA_W-1:0]    pwdata,
    output logic [cds_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic [15:0]                   status_word,
    output logic                          empty,
    input  logic                          pop,
    output logic                          command_valid,
    output logic [15:0]                   object_index,
    output logic signed [31:0]            write_value,
    output logic [3:0]                    drive_state,
    output logic                          state_diff,
    output logic                          last_result
);

    cds_pkg::cfg_t  cfg;
    cds_pkg::plan_t q_wr_data;
    cds_pkg::plan_t q_rd_data;
    logic           q_wr;
    logic           q_full;
    logic           q_valid;
    logic           q_rd;

    assign full = q_full;

    cds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cds_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .status_word (status_word),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_wr_data   (q_wr_data)
    );

    cds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data),
        .rd       (q_rd)
    );

    cds_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_data        (q_rd_data),
        .q_rd          (q_rd),
        .empty         (empty),
        .pop           (pop),
        .command_valid (command_valid),
        .object_index  (object_index),
        .write_value   (write_value),
        .drive_state   (drive_state),
        .state_diff    (state_diff),
        .last_result   (last_result)
    );

endmodule

// ===== rtl/cds_regs.sv =====
module cds_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cds_pkg::ADDR_W-1:0]    paddr,
    input  logic [cds_pkg::DATA_W-1:0]    pwdata,
    output logic [cds_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output cds_pkg::cfg_t                 cfg
);

    cds_pkg::cfg_t       cfg_reg;
    cds_pkg::reg_index_t sel;
    logic                wr_en;

    assign sel    = cds_pkg::reg_index_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (sel)
                cds_pkg::REG_VELOCITY_SETPOINT: cfg_reg.velocity_setpoint <= pwdata;
                cds_pkg::REG_PROFILE_ACCEL:     cfg_reg.profile_accel     <= pwdata[30:0];
                cds_pkg::REG_PROFILE_DECEL:     cfg_reg.profile_decel     <= pwdata[30:0];
                cds_pkg::REG_DRIVE_ENABLE:      cfg_reg.drive_enable      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            cds_pkg::REG_VELOCITY_SETPOINT: prdata = cfg_reg.velocity_setpoint;
            cds_pkg::REG_PROFILE_ACCEL:     prdata = {1'b0, cfg_reg.profile_accel};
            cds_pkg::REG_PROFILE_DECEL:     prdata = {1'b0, cfg_reg.profile_decel};
            cds_pkg::REG_DRIVE_ENABLE:      prdata = {31'd0, cfg_reg.drive_enable};
            default:                        prdata = '0;
        endcase
    end

endmodule

// ===== rtl/cds_front.sv =====
module cds_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [15:0]          status_word,
    input  logic                 q_full,
    output logic                 q_wr,
    output cds_pkg::plan_t       q_wr_data
);

    cds_pkg::drive_state_t last_state_reg;
    cds_pkg::drive_state_t dec_state;
    logic [6:0]            sw_a;
    logic [6:0]            sw_b;

    assign sw_a = status_word[6:0] & cds_pkg::MASK_A;
    assign sw_b = status_word[6:0] & cds_pkg::MASK_B;

    // The table is priority ordered: the fault patterns win over the rest.
    always_comb
    begin
        if (sw_a == cds_pkg::PAT_FREACT)      dec_state = cds_pkg::ST_FREACT;
        else if (sw_a == cds_pkg::PAT_FAULT)  dec_state = cds_pkg::ST_FAULT;
        else if (sw_a == cds_pkg::PAT_DISAB)  dec_state = cds_pkg::ST_DISABLED;
        else if (sw_a == cds_pkg::PAT_NREADY) dec_state = cds_pkg::ST_NOT_READY;
        else if (sw_b == cds_pkg::PAT_QSTOP)  dec_state = cds_pkg::ST_QSTOP;
        else if (sw_b == cds_pkg::PAT_ENAB)   dec_state = cds_pkg::ST_ENABLED;
        else if (sw_b == cds_pkg::PAT_SWON)   dec_state = cds_pkg::ST_SWITCHED;
        else if (sw_b == cds_pkg::PAT_READY)  dec_state = cds_pkg::ST_READY;
        else                                  dec_state = cds_pkg::ST_UNKNOWN;
    end

    assign q_wr              = push && !q_full;
    assign q_wr_data.state   = dec_state;
    assign q_wr_data.changed = (dec_state != last_state_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg <= cds_pkg::ST_UNKNOWN;
        end
        else if (q_wr)
        begin
            last_state_reg <= dec_state;
        end
    end

endmodule

// ===== rtl/cds_queue.sv =====
module cds_queue #(
    parameter int DEPTH = cds_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  cds_pkg::plan_t wr_data,
    output logic           full,
    output logic           rd_valid,
    output cds_pkg::plan_t rd_data,
    input  logic           rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cds_pkg::plan_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr && !full;
    assign do_rd    = rd && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> rd_valid)
    else $error("queue empty right after a write");

endmodule

// ===== rtl/cds_back.sv =====
module cds_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cds_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  cds_pkg::plan_t      q_data,
    output logic                q_rd,
    output logic                empty,
    input  logic                pop,
    output logic                command_valid,
    output logic [15:0]         object_index,
    output logic signed [31:0]  write_value,
    output logic [3:0]          drive_state,
    output logic                state_diff,
    output logic                last_result
);

    logic [1:0]         step_reg;
    logic               out_valid_reg;
    logic               cmd_valid_reg;
    logic [15:0]        index_reg;
    logic signed [31:0] value_reg;
    logic [3:0]         state_reg;
    logic               changed_reg;
    logic               last_reg;

    logic [1:0]         last_step;
    logic               e_valid;
    logic [15:0]        e_index;
    logic [31:0]        e_value;
    logic               load;
    logic               is_last;

    // Command table: last step index for the state and the write at this step.
    always_comb
    begin
        last_step = 2'd0;
        e_valid   = 1'b0;
        e_index   = '0;
        e_value   = '0;
        unique case (q_data.state)
            cds_pkg::ST_DISABLED:
            begin
                e_valid = 1'b1;
                e_index = cds_pkg::IDX_CONTROL;
                e_value = cds_pkg::CW_SHUTDOWN;
            end
            cds_pkg::ST_READY:
            begin
                e_valid = 1'b1;
                e_index = cds_pkg::IDX_CONTROL;
                e_value = cds_pkg::CW_SWITCH_ON;
            end
            cds_pkg::ST_SWITCHED:
            begin
                if (cfg.drive_enable)
                begin
                    last_step = 2'd3;
                    e_valid   = 1'b1;
                    case (step_reg)
                        2'd0:
                        begin
                            e_index = cds_pkg::IDX_MODE;
                            e_value = cds_pkg::MODE_PV;
                        end
                        2'd1:
                        begin
                            e_index = cds_pkg::IDX_ACCEL;
                            e_value = {1'b0, cfg.profile_accel};
                        end
                        2'd2:
                        begin
                            e_index = cds_pkg::IDX_DECEL;
                            e_value = {1'b0, cfg.profile_decel};
                        end
                        default:
                        begin
                            e_index = cds_pkg::IDX_CONTROL;
                            e_value = cds_pkg::CW_ENABLE_OP;
                        end
                    endcase
                end
            end
            cds_pkg::ST_ENABLED:
            begin
                e_valid = 1'b1;
                if (cfg.drive_enable)
                begin
                    e_index = cds_pkg::IDX_VELOCITY;
                    e_value = cfg.velocity_setpoint;
                end
                else
                begin
                    e_index = cds_pkg::IDX_CONTROL;
                    e_value = cds_pkg::CW_SWITCH_ON;
                end
            end
            cds_pkg::ST_QSTOP:
            begin
                e_valid = 1'b1;
                e_index = cds_pkg::IDX_CONTROL;
                e_value = cds_pkg::CW_ENABLE_OP;
            end
            cds_pkg::ST_FAULT:
            begin
                last_step = 2'd1;
                e_valid   = 1'b1;
                e_index   = cds_pkg::IDX_CONTROL;
                e_value   = (step_reg == 2'd0) ? cds_pkg::CW_DIS_VOLT : cds_pkg::CW_FAULT_RST;
            end
            default: ;
        endcase
    end

    // The output register takes a new result when it is free or being emptied.
    assign load    = q_valid && (!out_valid_reg || pop);
    assign is_last = (step_reg == last_step);
    assign q_rd    = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg      <= is_last ? 2'd0 : step_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_valid_reg <= e_valid;
            index_reg     <= e_index;
            value_reg     <= e_value;
            state_reg     <= q_data.state;
            changed_reg   <= q_data.changed;
            last_reg      <= is_last;
        end
    end

    assign empty         = !out_valid_reg;
    assign command_valid = cmd_valid_reg;
    assign object_index  = index_reg;
    assign write_value   = value_reg;
    assign drive_state   = state_reg;
    assign state_diff    = changed_reg;
    assign last_result   = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !cmd_valid_reg) |-> last_reg)
    else $error("result without a write is not the last of its item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != 2'd0) |-> q_valid)
    else $error("step count advanced with no item in the queue");

endmodule

// ===== test/tb_cia402_drive_enable_sequencer.sv =====
module tb_cia402_drive_enable_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import cds_pkg::*;

    typedef struct packed {
        logic         cmd_valid;
        logic [15:0]  obj_index;
        logic [31:0]  value;
        drive_state_t state;
        logic         changed;
        logic         last;
    } drive_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic        push = 1'b0;
    logic        full;
    logic [15:0] status_word = 16'h0000;
    logic        empty;
    logic        pop = 1'b0;

    logic               command_valid;
    logic [15:0]        object_index;
    logic signed [31:0] write_value;
    logic [3:0]         drive_state;
    logic               state_diff;
    logic               last_result;

    // Shadow copies of the block's registers and of its remembered state.
    cfg_t         drive_cfg = '0;
    drive_state_t prev_state = ST_UNKNOWN;

    logic [15:0] status_queue[$];
    drive_cmd_t  pending_cmds[$];
    int          mismatch_count = 0;

    int burst_left = 1;
    int gap_left = 0;

    logic [7:0] pop_pattern = 8'hFF;
    int         pop_phase = 0;

    cia402_drive_enable_sequencer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .status_word   (status_word),
        .empty         (empty),
        .pop           (pop),
        .command_valid (command_valid),
        .object_index  (object_index),
        .write_value   (write_value),
        .drive_state   (drive_state),
        .state_diff    (state_diff),
        .last_result   (last_result)
    );

    always #2 clk = ~clk;

    function automatic drive_state_t classify_status(input logic [15:0] sw);
        logic [6:0] a;
        logic [6:0] b;
        a = sw[6:0] & MASK_A;
        b = sw[6:0] & MASK_B;
        if (a == PAT_FREACT) return ST_FREACT;
        if (a == PAT_FAULT)  return ST_FAULT;
        if (a == PAT_DISAB)  return ST_DISABLED;
        if (a == PAT_NREADY) return ST_NOT_READY;
        if (b == PAT_QSTOP)  return ST_QSTOP;
        if (b == PAT_ENAB)   return ST_ENABLED;
        if (b == PAT_SWON)   return ST_SWITCHED;
        if (b == PAT_READY)  return ST_READY;
        return ST_UNKNOWN;
    endfunction

    task automatic predict_commands(input logic [15:0] sw);
        drive_state_t st;
        logic         chg;
        logic [15:0]  idx[$];
        logic [31:0]  val[$];
        drive_cmd_t   cmd;
        st = classify_status(sw);
        chg = (st != prev_state);
        prev_state = st;
        case (st)
            ST_DISABLED: begin
                idx.push_back(IDX_CONTROL); val.push_back(CW_SHUTDOWN);
            end
            ST_READY: begin
                idx.push_back(IDX_CONTROL); val.push_back(CW_SWITCH_ON);
            end
            ST_SWITCHED: begin
                if (drive_cfg.drive_enable)
                begin
                    idx.push_back(IDX_MODE);    val.push_back(MODE_PV);
                    idx.push_back(IDX_ACCEL);   val.push_back({1'b0, drive_cfg.profile_accel});
                    idx.push_back(IDX_DECEL);   val.push_back({1'b0, drive_cfg.profile_decel});
                    idx.push_back(IDX_CONTROL); val.push_back(CW_ENABLE_OP);
                end
            end
            ST_ENABLED: begin
                if (drive_cfg.drive_enable)
                begin
                    idx.push_back(IDX_VELOCITY); val.push_back(drive_cfg.velocity_setpoint);
                end
                else
                begin
                    idx.push_back(IDX_CONTROL); val.push_back(CW_SWITCH_ON);
                end
            end
            ST_QSTOP: begin
                idx.push_back(IDX_CONTROL); val.push_back(CW_ENABLE_OP);
            end
            ST_FAULT: begin
                idx.push_back(IDX_CONTROL); val.push_back(CW_DIS_VOLT);
                idx.push_back(IDX_CONTROL); val.push_back(CW_FAULT_RST);
            end
            default: ;
        endcase
        if (idx.size() == 0)
        begin
            cmd = '{1'b0, 16'h0000, 32'h0, st, chg, 1'b1};
            pending_cmds.push_back(cmd);
        end
        for (int k = 0; k < idx.size(); k++)
        begin
            cmd = '{1'b1, idx[k], val[k], st, chg, k == idx.size() - 1};
            pending_cmds.push_back(cmd);
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                predict_commands(status_word);
            if (!push || !full)
            begin
                if (gap_left > 0 || status_queue.size() == 0)
                begin
                    push <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    push <= 1'b1;
                    status_word <= status_queue.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: checks popped results; pops on a rotating pattern reloaded now and then.
    always @(posedge clk)
    begin
        drive_cmd_t exp_cmd;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_cmds.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, actual index %h value %h",
                             $realtime, object_index, write_value);
                end
                else
                begin
                    exp_cmd = pending_cmds.pop_front();
                    report_field("command_valid", 32'(exp_cmd.cmd_valid), 32'(command_valid));
                    report_field("object_index", 32'(exp_cmd.obj_index), 32'(object_index));
                    report_field("write_value", exp_cmd.value, write_value);
                    report_field("drive_state", 32'(exp_cmd.state), 32'(drive_state));
                    report_field("state_diff", 32'(exp_cmd.changed), 32'(state_diff));
                    report_field("last_result", 32'(exp_cmd.last), 32'(last_result));
                end
            end
            pop <= pop_pattern[pop_phase % 8];
            pop_phase++;
            if (pop_phase == 40)
            begin
                pop_phase = 0;
                if ($urandom_range(0, 3) == 0)
                    pop_pattern = 8'hFF;
                else
                    pop_pattern = 8'($urandom) | 8'h01;
            end
        end
    end

    task automatic write_reg(input reg_index_t r, input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({r, 2'b00});
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_VELOCITY_SETPOINT: drive_cfg.velocity_setpoint = v;
            REG_PROFILE_ACCEL:     drive_cfg.profile_accel = v[30:0];
            REG_PROFILE_DECEL:     drive_cfg.profile_decel = v[30:0];
            REG_DRIVE_ENABLE:      drive_cfg.drive_enable = v[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (status_queue.size() != 0 || push || pending_cmds.size() != 0);
    endtask

    // A statusword for the given state, with every bit outside its mask random.
    task automatic push_state(input drive_state_t s);
        logic [15:0] noise;
        noise = 16'($urandom);
        case (s)
            ST_NOT_READY: status_queue.push_back(16'(PAT_NREADY) | (noise & ~16'(MASK_A)));
            ST_DISABLED:  status_queue.push_back(16'(PAT_DISAB)  | (noise & ~16'(MASK_A)));
            ST_FREACT:    status_queue.push_back(16'(PAT_FREACT) | (noise & ~16'(MASK_A)));
            ST_FAULT:     status_queue.push_back(16'(PAT_FAULT)  | (noise & ~16'(MASK_A)));
            ST_READY:     status_queue.push_back(16'(PAT_READY)  | (noise & ~16'(MASK_B)));
            ST_SWITCHED:  status_queue.push_back(16'(PAT_SWON)   | (noise & ~16'(MASK_B)));
            ST_ENABLED:   status_queue.push_back(16'(PAT_ENAB)   | (noise & ~16'(MASK_B)));
            ST_QSTOP:     status_queue.push_back(16'(PAT_QSTOP)  | (noise & ~16'(MASK_B)));
            default:      status_queue.push_back(noise);
        endcase
    endtask

    // Mostly well-formed bring-up and recovery sequences, some raw noise.
    task automatic add_drive_traffic(input int count);
        int added;
        int kind;
        int reps;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                push_state(ST_DISABLED);
                push_state(ST_READY);
                push_state(ST_SWITCHED);
                reps = $urandom_range(1, 4);
                repeat (reps) push_state(ST_ENABLED);
                added += 3 + reps;
            end
            else if (kind == 6)
            begin
                reps = $urandom_range(0, 2);
                repeat (reps) push_state(ST_FREACT);
                push_state(ST_FAULT);
                if ($urandom_range(0, 1))
                begin
                    push_state(ST_FAULT);
                    added++;
                end
                push_state(ST_DISABLED);
                added += reps + 2;
            end
            else if (kind == 7)
            begin
                push_state(ST_ENABLED);
                push_state(ST_QSTOP);
                push_state(ST_QSTOP);
                push_state(ST_ENABLED);
                added += 4;
            end
            else if (kind == 8)
            begin
                push_state(ST_NOT_READY);
                push_state(ST_SWITCHED);
                push_state(ST_DISABLED);
                added += 3;
            end
            else
            begin
                reps = $urandom_range(1, 3);
                repeat (reps) status_queue.push_back(16'($urandom));
                added += reps;
            end
        end
    endtask

    initial
    begin
        logic [31:0] en_word;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at reset values: every state once, repeats, upper bits set.
        status_queue = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0040, 16'h0021, 16'h0023,
                         16'h0027, 16'h0007, 16'h000F, 16'h0008, 16'h0008, 16'hFFD8,
                         16'hFFB7};
        wait_drained();

        // Extreme settings: bit 31 of the acceleration word must be dropped.
        write_reg(REG_VELOCITY_SETPOINT, 32'h7FFF_FFFF);
        write_reg(REG_PROFILE_ACCEL, 32'hFFFF_FFFF);
        write_reg(REG_PROFILE_DECEL, 32'h0000_0000);
        write_reg(REG_DRIVE_ENABLE, 32'h0000_0001);
        status_queue = '{16'h0023, 16'hFFB3, 16'h0027, 16'hFFB7, 16'h0007, 16'h0027,
                         16'h0021, 16'h0040, 16'hFFAF};
        wait_drained();

        write_reg(REG_VELOCITY_SETPOINT, 32'h8000_0000);
        write_reg(REG_PROFILE_ACCEL, 32'h0000_0000);
        write_reg(REG_PROFILE_DECEL, 32'h7FFF_FFFF);
        add_drive_traffic(25);
        wait_drained();

        repeat (2)
        begin
            write_reg(REG_VELOCITY_SETPOINT, $urandom);
            write_reg(REG_PROFILE_ACCEL, $urandom);
            write_reg(REG_PROFILE_DECEL, $urandom);
            en_word = $urandom;
            en_word[0] = ($urandom_range(0, 3) != 0);
            write_reg(REG_DRIVE_ENABLE, en_word);
            add_drive_traffic(25);
            wait_drained();
        end

        write_reg(REG_VELOCITY_SETPOINT, 32'hFFFF_FFFF);
        write_reg(REG_DRIVE_ENABLE, 32'hFFFF_FFFE);
        add_drive_traffic(20);
        wait_drained();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_cia402_drive_enable_sequencer: done, clean");
        else
            $display("tb_cia402_drive_enable_sequencer: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_cia402_drive_enable_sequencer: done, errors");
        $finish;
    end

endmodule

// ===== cia402_drive_enable_sequencer.f =====
rtl/cds_pkg.sv
rtl/cds_regs.sv
rtl/cds_front.sv
rtl/cds_queue.sv
rtl/cds_back.sv
rtl/cia402_drive_enable_sequencer.sv
test/tb_cia402_drive_enable_sequencer.sv
